// ===== rtl/stepper_target_indexer_core_macros.svh =====
// Assertion macros shared by the stepper indexer RTL.
// No dependencies; included by the top level only.
`ifndef STEPPER_TARGET_INDEXER_CORE_MACROS_SVH
`define STEPPER_TARGET_INDEXER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define STI_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stepper indexer check failed");

// Next-cycle implication, disabled while in reset.
`define STI_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stepper indexer check failed");

`endif

// ===== rtl/sti_pkg.sv =====
// Shared types and constants for the stepper target indexer.
// No dependencies; used by sti_step_unit and the top level.
package sti_pkg;

    localparam int NUM_POS     = 5;
    localparam int POS_W       = 16;
    localparam int MASK_W      = 5;
    localparam int TICK_W      = 16;
    localparam int REACH_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int MS_W        = 32;
    localparam int PHASE_W     = 2;
    localparam int STEP_GAP_MS = 2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SEEK  = 2'd1,
        CMD_HOME  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_ONE   = 3'd0,
        REG_POS_TWO   = 3'd1,
        REG_POS_THREE = 3'd2,
        REG_POS_FOUR  = 3'd3,
        REG_POS_FIVE  = 3'd4,
        REG_LIMIT     = 3'd5
    } cfg_reg_t;

    localparam logic [PHASE_W-1:0] PH_HIGH = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LOW  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD = 2'd2;

    // Motor and mode state of fixed width
    typedef struct packed {
        logic              seeking;
        logic [MS_W-1:0]   last_step_ms;
        logic [PHASE_W-1:0] step_phase;
        logic              step_out;
        logic              direction_out;
        logic              enable_out;
        logic              home_found;
    } motor_state_t;

    typedef struct packed {
        logic               enable_level;
        logic               direction_level;
        logic               step_level;
        logic               moving;
        logic               at_home;
        logic               dwell;
        logic [REACH_W-1:0] reached_target;
        logic [TICK_W-1:0]  tick_count;
        logic [MASK_W-1:0]  pending_mask;
    } result_t;

endpackage

// ===== rtl/stepper_target_indexer_core.sv =====
// Stepper target indexer top level: input register, step logic, result register.
// Depends on sti_pkg, sti_step_unit and stepper_target_indexer_core_macros.svh.
//
// Usage:
//   One command per transfer on the s_axis side (tuser = command, tdata = target
//   mask, home switch, millisecond time). Each command produces exactly one
//   result transfer on the m_axis side with the pin levels, dwell flag, reached
//   target index, reported tick count and remaining pending targets.
//   Positions and the count limit are written through cfg_we/cfg_index/cfg_data
//   while no command is in flight.
// Flow:
//   A command is held in the input register, passes the step logic and lands
//   in the result register, which drives m_axis_tvalid. One command per cycle
//   sustained while m_axis_tready stays high; state commits as the command
//   enters the result register, so back-to-back commands see each other's effects.
// Reset:
//   Pending targets, count, step timing cleared; direction counter-clockwise,
//   motor disabled; positions 0, count limit 65535. Both stages empty.
// Stall:
//   While m_axis_tready is low the result register holds; one more command is
//   taken into the input register, then s_axis_tready drops until the result
//   is transferred.
`include "stepper_target_indexer_core_macros.svh"

module stepper_target_indexer_core #(
    parameter int COUNT_BITS = 16,
    parameter int TARGETS    = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    // command in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [4:0] target_mask, [5] home_switch,
                                        // [37:6] now_ms, [39:38] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    // result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] enable_level, [1] direction_level,
                                        // [2] step_level, [3] moving, [4] at_home,
                                        // [5] dwell, [8:6] reached_target,
                                        // [24:9] tick_count, [29:25] pending_mask,
                                        // [31:30] zero
    // configuration writes
    input  logic                             cfg_we,
    input  logic [sti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sti_pkg::POS_W-1:0]        cfg_data
);

    // configuration registers
    logic [sti_pkg::POS_W-1:0] pos_reg [sti_pkg::NUM_POS];
    logic [sti_pkg::POS_W-1:0] limit_reg;

    // architectural state
    logic [COUNT_BITS-1:0]     count_reg;
    logic [COUNT_BITS-1:0]     count_next;
    logic [TARGETS-1:0]        pending_reg;
    logic [TARGETS-1:0]        pending_next;
    sti_pkg::motor_state_t     motor_reg;
    sti_pkg::motor_state_t     motor_next;

    // input stage
    logic                      in_valid_reg;
    sti_pkg::cmd_t             in_cmd_reg;
    logic [sti_pkg::MASK_W-1:0] in_mask_reg;
    logic                      in_home_reg;
    logic [sti_pkg::MS_W-1:0]  in_now_reg;

    // result stage
    logic                      out_valid_reg;
    sti_pkg::result_t          out_reg;
    sti_pkg::result_t          result;

    logic                      advance;
    logic                      in_take;

    // command moves into the result stage when that stage is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    sti_step_unit #(
        .COUNT_BITS (COUNT_BITS),
        .TARGETS    (TARGETS)
    ) u_step (
        .cmd          (in_cmd_reg),
        .target_mask  (in_mask_reg),
        .home_switch  (in_home_reg),
        .now_ms       (in_now_reg),
        .count_cur    (count_reg),
        .pending_cur  (pending_reg),
        .motor_cur    (motor_reg),
        .positions    (pos_reg),
        .count_limit  (limit_reg),
        .count_next   (count_next),
        .pending_next (pending_next),
        .motor_next   (motor_next),
        .result       (result)
    );

    // configuration port; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sti_pkg::NUM_POS; i++)
                pos_reg[i] <= '0;
            limit_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sti_pkg::REG_POS_ONE:   pos_reg[0] <= cfg_data;
                sti_pkg::REG_POS_TWO:   pos_reg[1] <= cfg_data;
                sti_pkg::REG_POS_THREE: pos_reg[2] <= cfg_data;
                sti_pkg::REG_POS_FOUR:  pos_reg[3] <= cfg_data;
                sti_pkg::REG_POS_FIVE:  pos_reg[4] <= cfg_data;
                sti_pkg::REG_LIMIT:     limit_reg  <= cfg_data;
                default:                limit_reg  <= limit_reg;
            endcase
        end
    end

    // state commits when a command passes the step logic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg               <= '0;
            pending_reg             <= '0;
            motor_reg.seeking       <= 1'b0;
            motor_reg.last_step_ms  <= '0;
            motor_reg.step_phase    <= sti_pkg::PH_HIGH;
            motor_reg.step_out      <= 1'b0;
            motor_reg.direction_out <= 1'b1;
            motor_reg.enable_out    <= 1'b1;
            motor_reg.home_found    <= 1'b0;
        end
        else if (advance)
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
            motor_reg   <= motor_next;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= sti_pkg::cmd_t'(s_axis_tuser);
            in_mask_reg <= s_axis_tdata[4:0];
            in_home_reg <= s_axis_tdata[5];
            in_now_reg  <= s_axis_tdata[37:6];
        end
        if (advance)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00,
                            out_reg.pending_mask,
                            out_reg.tick_count,
                            out_reg.reached_target,
                            out_reg.dwell,
                            out_reg.at_home,
                            out_reg.moving,
                            out_reg.step_level,
                            out_reg.direction_level,
                            out_reg.enable_level};

    // checks
    // a reported dwell always names the target that was reached
    `STI_ASSERT_IMP(a_dwell_has_target, clk, rst_n,
        out_valid_reg && out_reg.dwell, out_reg.reached_target != 3'd0)
    // home found only ever coexists with a disabled motor
    `STI_ASSERT_IMP(a_home_stopped, clk, rst_n,
        out_valid_reg && out_reg.at_home, !out_reg.moving)
    // a command blocked by a stalled result stays in the input register
    `STI_ASSERT_NXT(a_in_hold, clk, rst_n,
        in_valid_reg && !advance, in_valid_reg && $stable(in_now_reg))

endmodule

// ===== rtl/sti_step_unit.sv =====
// Next-state and result logic for one command of the stepper indexer.
// Depends on sti_pkg; purely combinational.
module sti_step_unit #(
    parameter int COUNT_BITS = 16,
    parameter int TARGETS    = 5
) (
    input  sti_pkg::cmd_t                      cmd,
    input  logic [sti_pkg::MASK_W-1:0]         target_mask,
    input  logic                               home_switch,
    input  logic [sti_pkg::MS_W-1:0]           now_ms,
    input  logic [COUNT_BITS-1:0]              count_cur,
    input  logic [TARGETS-1:0]                 pending_cur,
    input  sti_pkg::motor_state_t              motor_cur,
    input  logic [sti_pkg::POS_W-1:0]          positions [sti_pkg::NUM_POS],
    input  logic [sti_pkg::POS_W-1:0]          count_limit,
    output logic [COUNT_BITS-1:0]              count_next,
    output logic [TARGETS-1:0]                 pending_next,
    output sti_pkg::motor_state_t              motor_next,
    output sti_pkg::result_t                   result
);

    localparam int CW = (COUNT_BITS > sti_pkg::POS_W) ? COUNT_BITS : sti_pkg::POS_W;

    logic [CW-1:0]              count_w;
    logic [CW-1:0]              count_inc;
    logic [CW-1:0]              report;
    logic [sti_pkg::MS_W-1:0]   elapsed;
    logic                       step_due;
    sti_pkg::motor_state_t      motor_run;
    logic                       found;
    logic [$clog2(TARGETS+1)-1:0] hit_idx;
    logic [3:0]                 reached;
    logic                       dwell;
    logic [CW-1:0]              hit_pos;
    logic [7:0]                 pend_wide;

    assign count_w = CW'(count_cur);

    // saturating increment: stops at count_limit or all-ones
    assign count_inc = ((count_w < CW'(count_limit)) && !(&count_cur))
                       ? count_w + CW'(1) : count_w;

    // step pattern: high, low, hold; one phase when more than 2 ms elapsed
    assign elapsed  = now_ms - motor_cur.last_step_ms;
    assign step_due = elapsed > sti_pkg::MS_W'(sti_pkg::STEP_GAP_MS);

    always_comb
    begin
        motor_run            = motor_cur;
        motor_run.enable_out = 1'b0;
        if (step_due)
        begin
            if (motor_cur.step_phase == sti_pkg::PH_HIGH)
                motor_run.step_out = 1'b1;
            else if (motor_cur.step_phase == sti_pkg::PH_LOW)
                motor_run.step_out = 1'b0;
            motor_run.step_phase = (motor_cur.step_phase >= sti_pkg::PH_HOLD)
                                   ? sti_pkg::PH_HIGH
                                   : motor_cur.step_phase + sti_pkg::PHASE_W'(1);
            motor_run.last_step_ms = now_ms;
        end
    end

    always_comb
    begin
        count_next   = count_cur;
        pending_next = pending_cur;
        motor_next   = motor_cur;
        report       = count_w;
        dwell        = 1'b0;
        reached      = 4'd0;
        found        = 1'b0;
        hit_idx      = '0;
        hit_pos      = '0;
        case (cmd)
            sti_pkg::CMD_LOAD:
            begin
                pending_next       = TARGETS'(target_mask);
                motor_next.seeking = 1'b1;
            end
            sti_pkg::CMD_SEEK:
            begin
                if (motor_cur.seeking)
                begin
                    motor_next               = motor_run;
                    motor_next.direction_out = 1'b0;
                    motor_next.home_found    = 1'b0;
                    report                   = count_inc;
                    count_next               = COUNT_BITS'(count_inc);
                end
                if (pending_cur == '0)
                begin
                    motor_next.seeking    = 1'b0;
                    motor_next.enable_out = 1'b1;
                    count_next            = '0;
                end
                else
                begin
                    // lowest pending target wins
                    for (int i = TARGETS - 1; i >= 0; i--)
                    begin
                        if (pending_cur[i])
                        begin
                            found   = 1'b1;
                            hit_idx = ($clog2(TARGETS+1))'(i);
                            hit_pos = (i < sti_pkg::NUM_POS) ? CW'(positions[i]) : '0;
                        end
                    end
                    if (found && (report >= hit_pos))
                    begin
                        pending_next[hit_idx] = 1'b0;
                        dwell                 = 1'b1;
                        reached               = 4'(hit_idx) + 4'd1;
                        motor_next.enable_out = 1'b0;
                    end
                end
            end
            sti_pkg::CMD_HOME:
            begin
                if (!home_switch)
                begin
                    motor_next               = motor_run;
                    motor_next.direction_out = 1'b1;
                    motor_next.home_found    = 1'b0;
                    report                   = count_inc;
                    count_next               = COUNT_BITS'(count_inc);
                end
                else
                begin
                    motor_next.enable_out    = 1'b1;
                    motor_next.direction_out = 1'b0;
                    motor_next.home_found    = 1'b1;
                    count_next               = '0;
                end
            end
            sti_pkg::CMD_CLEAR:
            begin
                count_next = '0;
                report     = '0;
            end
            default:
            begin
                count_next = count_cur;
            end
        endcase
    end

    assign pend_wide = 8'(pending_next);

    always_comb
    begin
        result.enable_level    = motor_next.enable_out;
        result.direction_level = motor_next.direction_out;
        result.step_level      = motor_next.step_out;
        result.moving          = !motor_next.enable_out;
        result.at_home         = motor_next.home_found;
        result.dwell           = dwell;
        result.reached_target  = reached[sti_pkg::REACH_W-1:0];
        result.tick_count      = report[sti_pkg::TICK_W-1:0];
        result.pending_mask    = pend_wide[sti_pkg::MASK_W-1:0];
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for stepper_target_indexer_core.
// Depends on sti_pkg; drives the command stream and the config port, predicts every
// result transfer in a small scoreboard class and compares it field by field.
`timescale 1ns / 100ps

module testbench;
    import sti_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_PER_PH  = 206;
    localparam int PHASES         = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int CYCLE_LIMIT    = 250000;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of indexer state, queue of predicted results
    // ------------------------------------------------------------------
    class indexer_tracker;
        bit [15:0] target_pos[5];
        bit [15:0] count_cap   = 16'hFFFF;
        bit [4:0]  armed_mask  = '0;
        bit        armed       = 1'b0;
        bit [15:0] steps       = '0;
        bit [31:0] last_ms     = '0;
        bit [1:0]  pulse_phase = '0;
        bit        pulse_pin   = 1'b0;
        bit        dir_pin     = 1'b1;
        bit        en_pin      = 1'b1;
        bit        homed       = 1'b0;
        result_t   predicted[$];
        int        errors      = 0;
        int        seen        = 0;

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void write_reg(cfg_reg_t idx, bit [15:0] val);
            if (idx == REG_LIMIT)
                count_cap = val;
            else
                target_pos[idx] = val;
        endfunction

        function void bump_count();
            if (steps < count_cap)
                steps++;
        endfunction

        // one phase of the high/low/hold step pattern when >2 ms elapsed
        function void drive_motor(bit [31:0] now);
            bit [31:0] gap;
            gap = now - last_ms;
            en_pin = 1'b0;
            if (gap > 32'd2)
            begin
                if (pulse_phase == PH_HIGH)
                    pulse_pin = 1'b1;
                else if (pulse_phase == PH_LOW)
                    pulse_pin = 1'b0;
                pulse_phase = (pulse_phase >= PH_HOLD) ? PH_HIGH : pulse_phase + 2'd1;
                last_ms = now;
            end
        endfunction

        function void note_command(cmd_t cmd, bit [4:0] mask, bit sw, bit [31:0] now);
            result_t   r;
            bit [15:0] shown;
            bit        dwell;
            bit [2:0]  hit;
            bit        done;
            dwell = 1'b0;
            hit   = '0;
            done  = 1'b0;
            shown = steps;
            case (cmd)
                CMD_LOAD:
                begin
                    armed_mask = mask;
                    armed      = 1'b1;
                    shown      = steps;
                end
                CMD_SEEK:
                begin
                    if (armed)
                    begin
                        bump_count();
                        dir_pin = 1'b0;
                        drive_motor(now);
                        homed = 1'b0;
                    end
                    shown = steps;
                    if (armed_mask == '0)
                    begin
                        armed  = 1'b0;
                        steps  = '0;
                        en_pin = 1'b1;
                    end
                    else
                    begin
                        // only the lowest pending target is looked at
                        for (int i = 0; i < 5; i++)
                        begin
                            if (!done && armed_mask[i])
                            begin
                                done = 1'b1;
                                if (steps >= target_pos[i])
                                begin
                                    armed_mask[i] = 1'b0;
                                    dwell  = 1'b1;
                                    hit    = 3'(i + 1);
                                    en_pin = 1'b0;
                                end
                            end
                        end
                    end
                end
                CMD_HOME:
                begin
                    if (!sw)
                    begin
                        dir_pin = 1'b1;
                        drive_motor(now);
                        homed = 1'b0;
                        bump_count();
                        shown = steps;
                    end
                    else
                    begin
                        en_pin  = 1'b1;
                        dir_pin = 1'b0;
                        homed   = 1'b1;
                        shown   = steps;
                        steps   = '0;
                    end
                end
                default:
                begin
                    steps = '0;
                    shown = '0;
                end
            endcase
            r.enable_level    = en_pin;
            r.direction_level = dir_pin;
            r.step_level      = pulse_pin;
            r.moving          = !en_pin;
            r.at_home         = homed;
            r.dwell           = dwell;
            r.reached_target  = hit;
            r.tick_count      = shown;
            r.pending_mask    = armed_mask;
            predicted.push_back(r);
        endfunction

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                          seen, name, got, want));
        endtask

        task check_result(logic [31:0] data);
            result_t want;
            if (predicted.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with none predicted", seen));
            end
            else
            begin
                want = predicted.pop_front();
                compare_field("enable_level", data[0], want.enable_level);
                compare_field("direction_level", data[1], want.direction_level);
                compare_field("step_level", data[2], want.step_level);
                compare_field("moving", data[3], want.moving);
                compare_field("at_home", data[4], want.at_home);
                compare_field("dwell", data[5], want.dwell);
                compare_field("reached_target", data[8:6], want.reached_target);
                compare_field("tick_count", data[24:9], want.tick_count);
                compare_field("pending_mask", data[29:25], want.pending_mask);
            end
            seen++;
        endtask

        function int outstanding();
            return predicted.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata;   // [4:0] target_mask, [5] home_switch,
                                          // [37:6] now_ms, [39:38] zero
    logic [1:0]           s_axis_tuser;   // [1:0] command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;   // [0] enable_level, [1] direction_level,
                                          // [2] step_level, [3] moving, [4] at_home,
                                          // [5] dwell, [8:6] reached_target,
                                          // [24:9] tick_count, [29:25] pending_mask
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POS_W-1:0]     cfg_data;

    indexer_tracker tracker = new;

    int        send_idle_pct;     // chance per cycle that the sender holds off
    int        recv_stall_pct;    // chance per cycle that the receiver stalls
    int        cycle_count;
    bit [31:0] stamp_ms;          // running millisecond clock for the stimulus
    bit [15:0] setting_pos[5];
    bit [15:0] setting_limit;

    stepper_target_indexer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // timeout watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random backpressure on the result side
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // monitor: every result transfer goes to the scoreboard
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // One command transfer; valid stays high after the handshake so that
    // back-to-back transfers never lower and raise it in one step.
    task automatic send_command(cmd_t cmd, bit [4:0] mask, bit sw, bit [31:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, now, sw, mask};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_command(cmd, mask, sw, now);
    endtask

    // sender holds off until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // block is idle: write all six registers, scoreboard follows
    task automatic load_setting();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(REG_POS_ONE + i);
            cfg_data  <= setting_pos[i];
            tracker.write_reg(cfg_reg_t'(REG_POS_ONE + i), setting_pos[i]);
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= REG_LIMIT;
        cfg_data  <= setting_limit;
        tracker.write_reg(REG_LIMIT, setting_limit);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly seek runs after loads so targets actually get reached; time
    // advances in small steps (exercising the 2 ms gate) with rare jumps.
    task automatic random_command();
        int   pick;
        cmd_t cmd;
        bit   sw;
        pick = $urandom_range(99);
        if (pick < 12)
            cmd = CMD_LOAD;
        else if (pick < 72)
            cmd = CMD_SEEK;
        else if (pick < 88)
            cmd = CMD_HOME;
        else
            cmd = CMD_CLEAR;
        sw = ($urandom_range(99) < 25);
        if ($urandom_range(99) < 8)
            stamp_ms = $urandom();
        else
            stamp_ms = stamp_ms + $urandom_range(0, 5);
        send_command(cmd, 5'($urandom_range(31)), sw, stamp_ms);
    endtask

    // per-phase register setting; extremes on phases two and three
    task automatic pick_setting(int ph);
        for (int i = 0; i < 5; i++)
        begin
            case (ph)
                1:       setting_pos[i] = 16'($urandom_range(0, 30));
                2:       setting_pos[i] = (i == 3) ? 16'hFFFF : 16'(i % 2);
                3:       setting_pos[i] = 16'hFFFF;
                default: setting_pos[i] = ($urandom_range(9) == 0) ? 16'($urandom())
                                                                  : 16'($urandom_range(0, 25));
            endcase
        end
        case (ph)
            1:       setting_limit = 16'($urandom_range(3, 40));
            2:       setting_limit = 16'h0000;
            3:       setting_limit = 16'hFFFF;
            default: setting_limit = ($urandom_range(1) == 0) ? 16'hFFFF
                                                              : 16'($urandom_range(0, 60));
        endcase
    endtask

    // idle profile cycles: none, sender, receiver, both
    task automatic pick_idling(int ph);
        case (ph % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= CMD_LOAD;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_POS_ONE;
        cfg_data       <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stamp_ms       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: targets at 0/2/4/6 plus an unreachable fifth
        setting_pos[0] = 16'd0;
        setting_pos[1] = 16'd2;
        setting_pos[2] = 16'd4;
        setting_pos[3] = 16'd6;
        setting_pos[4] = 16'hFFFF;
        setting_limit  = 16'hFFFF;
        load_setting();

        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd0);    // seek while not armed
        send_command(CMD_HOME,  5'd0,  1'b0, 32'd5);    // home move, step fires
        send_command(CMD_HOME,  5'd0,  1'b0, 32'd6);    // under 2 ms, no phase change
        send_command(CMD_HOME,  5'd0,  1'b1, 32'd7);    // switch closed: report, clear
        send_command(CMD_LOAD,  5'd31, 1'b0, 32'd8);    // all targets
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd10);
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd11);
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd14);
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd15);
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd20);
        send_command(CMD_CLEAR, 5'd31, 1'b1, 32'd21);
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd30);
        send_command(CMD_LOAD,  5'd0,  1'b0, 32'd31);   // armed with nothing pending
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd32);   // disarms, clears count
        send_command(CMD_LOAD,  5'd16, 1'b0, 32'd33);   // only the unreachable target
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'hFFFF_FFFF);
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd1);    // wrapped gap of exactly 2
        send_command(CMD_SEEK,  5'd0,  1'b0, 32'd2);    // wrapped gap of 3
        send_command(CMD_HOME,  5'd0,  1'b0, 32'd10);
        send_command(CMD_HOME,  5'd0,  1'b1, 32'd11);
        send_command(CMD_CLEAR, 5'd0,  1'b0, 32'd12);
        stamp_ms = 32'd12;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                pick_setting(ph);
                load_setting();
            end
            pick_idling(ph);
            for (int n = 0; n < RANDOM_PER_PH; n++)
            begin
                if (ph == 1 && n == 60)
                    drain_results();
                random_command();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
